### rtl/core/tcof_pkg.sv
`timescale 1ns / 1ps

package tcof_pkg;

    localparam int DATA_W   = 32;
    localparam int S_USER_W = 3;
    localparam int M_USER_W = 7;
    localparam int WIDE_W   = 64;

    typedef enum logic [1:0] {
        MODE_PUSH       = 2'd0,
        MODE_POP_ANY    = 2'd1,
        MODE_POP_FIRST  = 2'd2,
        MODE_POP_SECOND = 2'd3
    } mode_t;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic CLASS_FIRST  = 1'b0;
    localparam logic CLASS_SECOND = 1'b1;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic empty_next;
    } q_stat_t;

endpackage

### rtl/core/two_class_ordered_fifo.sv
`timescale 1ns / 1ps
// Channel  Direction  Fields (lowest bit up)
// s_axis   in         tdata: payload; tuser: mode[1:0], item_class[2]
// m_axis   out        tdata: out_payload; tuser: got_item, out_class, status[3:2],
//                     all_empty, first_empty, second_empty
//
// While m_axis_tready is high, one transfer per cycle is taken and one result per cycle delivered.
// A result reaches m_axis through the input register, then the result register.
// Queue heads sit in registers reloaded every cycle from the queue memory or the pushed entry.
// Reset clears pointers, fill counts and the stamp counter; the stores are not cleared.
// With m_axis_tready low the result holds, then the input register fills and s_axis_tready drops.

module two_class_ordered_fifo #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32,
    parameter int STAMP_BITS   = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [tcof_pkg::DATA_W-1:0]     s_axis_tdata,   // payload
    input  logic [tcof_pkg::S_USER_W-1:0]   s_axis_tuser,   // mode, item_class
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [tcof_pkg::DATA_W-1:0]     m_axis_tdata,   // out_payload
    output logic [tcof_pkg::M_USER_W-1:0]   m_axis_tuser    // got_item, out_class, status,
                                                            // all_empty, first_empty,
                                                            // second_empty
);
    import tcof_pkg::*;

    localparam int ENTRY_W = STAMP_BITS + PAYLOAD_BITS;

    logic                    in_valid_reg;
    mode_t                   in_mode_reg;
    logic                    in_class_reg;
    logic [PAYLOAD_BITS-1:0] in_payload_reg;
    logic [WIDE_W-1:0]       in_wide;

    logic                    out_valid_reg;
    logic [DATA_W-1:0]       out_data_reg;
    logic [M_USER_W-1:0]     out_user_reg;
    logic [DATA_W-1:0]       out_data_next;
    logic [M_USER_W-1:0]     out_user_next;

    logic [STAMP_BITS-1:0]   stamp_reg;
    logic [STAMP_BITS-1:0]   stamp_next;

    logic                    proc;
    q_ctrl_t                 first_ctrl;
    q_ctrl_t                 second_ctrl;
    q_stat_t                 first_stat;
    q_stat_t                 second_stat;
    logic [ENTRY_W-1:0]      wr_entry;
    logic [ENTRY_W-1:0]      first_head;
    logic [ENTRY_W-1:0]      second_head;
    logic [STAMP_BITS-1:0]   stamp_diff;
    logic                    first_older;
    logic                    take_first;
    logic                    take_second;
    logic [1:0]              status;
    logic [PAYLOAD_BITS-1:0] pay_sel;
    logic [WIDE_W-1:0]       out_wide;
    logic                    got_item;
    logic                    out_class;

    assign proc          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;
    assign in_wide       = WIDE_W'(s_axis_tdata);
    assign wr_entry      = {stamp_reg, in_payload_reg};

    assign stamp_diff  = second_head[ENTRY_W-1:PAYLOAD_BITS] - first_head[ENTRY_W-1:PAYLOAD_BITS];
    assign first_older = (stamp_diff != '0) && !stamp_diff[STAMP_BITS-1];

    always_comb
    begin
        first_ctrl  = '0;
        second_ctrl = '0;
        take_first  = 1'b0;
        take_second = 1'b0;
        status      = STAT_OK;
        case (in_mode_reg)
            MODE_PUSH:
            begin
                if (in_class_reg == CLASS_SECOND)
                begin
                    if (second_stat.full)
                        status = STAT_FULL;
                    else
                        second_ctrl.push = proc;
                end
                else
                begin
                    if (first_stat.full)
                        status = STAT_FULL;
                    else
                        first_ctrl.push = proc;
                end
            end
            MODE_POP_ANY:
            begin
                if (!first_stat.empty && !second_stat.empty)
                begin
                    take_first  = first_older;
                    take_second = !first_older;
                end
                else if (!first_stat.empty)
                    take_first = 1'b1;
                else if (!second_stat.empty)
                    take_second = 1'b1;
                else
                    status = STAT_EMPTY;
            end
            MODE_POP_FIRST:
            begin
                if (!first_stat.empty)
                    take_first = 1'b1;
                else
                    status = STAT_EMPTY;
            end
            MODE_POP_SECOND:
            begin
                if (!second_stat.empty)
                    take_second = 1'b1;
                else
                    status = STAT_EMPTY;
            end
            default:
            begin
                status = STAT_OK;
            end
        endcase
        first_ctrl.pop  = proc && take_first;
        second_ctrl.pop = proc && take_second;
    end

    always_comb
    begin
        stamp_next = stamp_reg;
        if (first_ctrl.push || second_ctrl.push)
            stamp_next = stamp_reg + 1'b1;

        got_item  = take_first || take_second;
        out_class = take_second ? CLASS_SECOND : CLASS_FIRST;
        if (take_first)
            pay_sel = first_head[PAYLOAD_BITS-1:0];
        else if (take_second)
            pay_sel = second_head[PAYLOAD_BITS-1:0];
        else
            pay_sel = '0;
        out_wide      = WIDE_W'(pay_sel);
        out_data_next = out_wide[DATA_W-1:0];
        out_user_next = {second_stat.empty_next,
                         first_stat.empty_next,
                         first_stat.empty_next && second_stat.empty_next,
                         status, out_class, got_item};
    end

    tcof_queue #(
        .DEPTH   (DEPTH),
        .ENTRY_W (ENTRY_W)
    ) u_first_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (first_ctrl),
        .wr_entry   (wr_entry),
        .head_entry (first_head),
        .stat       (first_stat)
    );

    tcof_queue #(
        .DEPTH   (DEPTH),
        .ENTRY_W (ENTRY_W)
    ) u_second_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (second_ctrl),
        .wr_entry   (wr_entry),
        .head_entry (second_head),
        .stat       (second_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stamp_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (proc)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            stamp_reg <= stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_mode_reg    <= mode_t'(s_axis_tuser[1:0]);
            in_class_reg   <= s_axis_tuser[2];
            in_payload_reg <= in_wide[PAYLOAD_BITS-1:0];
        end
        if (proc)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

### rtl/core/tcof_queue.sv
`timescale 1ns / 1ps

module tcof_queue #(
    parameter int DEPTH   = 16,
    parameter int ENTRY_W = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcof_pkg::q_ctrl_t    ctrl,
    input  logic [ENTRY_W-1:0]   wr_entry,
    output logic [ENTRY_W-1:0]   head_entry,
    output tcof_pkg::q_stat_t    stat
);
    import tcof_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);
    localparam logic [FILL_W-1:0] ONE_FILL  = FILL_W'(1);

    logic [ENTRY_W-1:0] store_reg [DEPTH];
    logic [ENTRY_W-1:0] head_entry_reg;
    logic [PTR_W-1:0]   head_ptr_reg;
    logic [PTR_W-1:0]   head_ptr_next;
    logic [PTR_W-1:0]   tail_ptr_reg;
    logic [PTR_W-1:0]   tail_ptr_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;

    always_comb
    begin
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        fill_next     = fill_reg;
        if (ctrl.pop)
        begin
            head_ptr_next = (head_ptr_reg == LAST_PTR) ? '0 : head_ptr_reg + 1'b1;
        end
        if (ctrl.push)
        begin
            tail_ptr_next = (tail_ptr_reg == LAST_PTR) ? '0 : tail_ptr_reg + 1'b1;
        end
        case ({ctrl.push, ctrl.pop})
            2'b10:   fill_next = fill_reg + ONE_FILL;
            2'b01:   fill_next = fill_reg - ONE_FILL;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            fill_reg     <= fill_next;
        end
    end

    // The head register is reloaded from the entry that becomes the head; a push into
    // an empty queue writes that same entry, so the new data is forwarded.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            store_reg[tail_ptr_reg] <= wr_entry;
        end
        if (ctrl.push && (tail_ptr_reg == head_ptr_next))
        begin
            head_entry_reg <= wr_entry;
        end
        else
        begin
            head_entry_reg <= store_reg[head_ptr_next];
        end
    end

    assign head_entry      = head_entry_reg;
    assign stat.empty      = (fill_reg == '0);
    assign stat.full       = (fill_reg == FULL_FILL);
    assign stat.empty_next = (fill_next == '0);

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_FILL)
        else $error("Queue fill count exceeds its depth.");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> !stat.empty)
        else $error("Pop issued to an empty queue.");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |-> !stat.full)
        else $error("Push issued to a full queue.");

    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |=> !stat.empty)
        else $error("Queue is empty right after a push.");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.empty || stat.full) |-> (head_ptr_reg == tail_ptr_reg))
        else $error("Pointers disagree with an empty or full queue.");
`endif

endmodule
